// File: src/firing_duration_profiler_defines.svh
// ----------------------------------------------------------------------------
// Firing duration profiler assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIRING_DURATION_PROFILER_DEFINES_SVH
`define FIRING_DURATION_PROFILER_DEFINES_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define FDP_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons starts in the following cycle.
`define FDP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/fdp_pkg.sv
// ----------------------------------------------------------------------------
// Firing duration profiler package
// Item types, codes and sizes used by all modules but the RAM, and the statistics update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdp_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int ACTIONS     = 16;
   localparam int ACTION_AW   = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;
   localparam int MASK_W      = 16;
   localparam int TICK_W      = 64;
   localparam int INDEX_W     = 4;

   typedef enum logic [1:0] {
      ACT_START   = 2'd0,
      ACT_END     = 2'd1,
      ACT_DISCARD = 2'd2,
      ACT_READ    = 2'd3
   } action_code_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_DISABLED = 2'd3
   } status_code_type;

   typedef struct packed {
      action_code_type      action;
      logic [TICK_W-1:0]    timestamp;
      logic [INDEX_W-1:0]   act_slot;
      logic                 read_global;
   } req_item_type;

   typedef struct packed {
      status_code_type      status;
      logic [TICK_W-1:0]    duration;
      logic [TICK_W-1:0]    count_firings;
      logic [TICK_W-1:0]    sum_ticks;
      logic [TICK_W-1:0]    least_ticks;
      logic [TICK_W-1:0]    most_ticks;
      logic [TICK_W-1:0]    missed_count;
      logic [TICK_W-1:0]    missed_ticks;
   } rsp_item_type;

   // One statistics record: global or per action.
   typedef struct packed {
      logic [TICK_W-1:0] firings;
      logic [TICK_W-1:0] total;
      logic [TICK_W-1:0] least;
      logic [TICK_W-1:0] most;
   } stats_type;

   localparam int STATS_W = $bits(stats_type);

   localparam stats_type STATS_RESET = '{
      firings: '0,
      total:   '0,
      least:   '1,
      most:    '0
   };

   typedef struct packed {
      logic rd_en;
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_stat_type;

   typedef struct packed {
      logic                 rd_en;
      logic                 wr_en;
      logic [ACTION_AW-1:0] index;
   } stats_ctl_type;

   // Fold one firing duration into a record.
   function automatic stats_type stats_add(stats_type s, logic [TICK_W-1:0] dur);
      stats_type r;
      r         = s;
      r.total   = s.total + dur;
      r.firings = s.firings + TICK_W'(1);
      if (dur < s.least) begin
         r.least = dur;
      end
      if (dur > s.most) begin
         r.most = dur;
      end
      return r;
   endfunction

endpackage

// File: src/firing_duration_profiler.sv
// ----------------------------------------------------------------------------
// Firing duration profiler
// Times actor firings from start/end events and keeps global, per-action
// and miss statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_item and raise start; the item is taken at an edge
//   where start is high and busy is low. busy stays high while an item is in
//   flight, so at most one item is worked on at a time.
//   Response: rsp_valid pulses for one cycle with rsp_item after the item
//   passes the READ, CALC and UPDATE states and the output register. The
//   receiver must take it then; it cannot stall. The next item is taken
//   after UPDATE. The loop is read (queue head and action record from
//   RAM), subtract, then update and write back; a start item walks it too.
//   Configuration: csr_valid with csr_data writes the action enable mask;
//   csr_ready is always high. Write it only while the block is idle.
//   Reset: clears queue pointers, global and miss statistics, the enable
//   mask and the per-action valid bits; the start queue RAM holds no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "firing_duration_profiler_defines.svh"

module firing_duration_profiler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  fdp_pkg::req_item_type         req_item,
   output logic                          rsp_valid,
   output fdp_pkg::rsp_item_type         rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fdp_pkg::MASK_W-1:0]    csr_data
);

   import fdp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CALC,
      S_UPDATE
   } state_type;

   state_type          state_ff, state_in;
   req_item_type       item_ff, item_in;
   logic [TICK_W-1:0]  diff_ff, diff_in;
   stats_type          glob_ff, glob_in;
   logic [TICK_W-1:0]  miss_count_ff, miss_count_in;
   logic [TICK_W-1:0]  miss_ticks_ff, miss_ticks_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   queue_ctl_type      q_ctl;
   queue_stat_type     q_stat;
   logic [TICK_W-1:0]  head_data;
   stats_ctl_type      st_ctl;
   stats_type          st_rd;
   stats_type          act_sel;
   stats_type          act_new;
   logic               in_range;
   logic               enabled;
   logic [TICK_W-1:0]  dur_end;
   logic               accept;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // An index past the action count is never enabled and reads as reset.
   assign in_range = (32'(item_ff.act_slot) < ACTIONS);
   assign enabled  = in_range && mask_ff[item_ff.act_slot];
   assign act_sel  = in_range ? st_rd : STATS_RESET;

   // End durations are at least one tick.
   assign dur_end = (diff_ff == '0) ? TICK_W'(1) : diff_ff;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      diff_in       = diff_ff;
      glob_in       = glob_ff;
      miss_count_in = miss_count_ff;
      miss_ticks_in = miss_ticks_ff;
      mask_in       = mask_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = rsp_item_ff;
      act_new       = act_sel;
      q_ctl         = '0;
      st_ctl        = '0;
      st_ctl.index  = ACTION_AW'(item_ff.act_slot);

      if (csr_valid) begin
         mask_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               item_in  = req_item;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // Fetch the oldest start and the action record.
            q_ctl.rd_en  = 1'b1;
            st_ctl.rd_en = 1'b1;
            state_in     = S_CALC;
         end
         S_CALC: begin
            diff_in  = item_ff.timestamp - head_data;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            rsp_item_in.status   = STAT_OK;
            rsp_item_in.duration = '0;
            unique case (item_ff.action)
               ACT_START: begin
                  if (q_stat.full) begin
                     rsp_item_in.status = STAT_FULL;
                  end else begin
                     q_ctl.push = 1'b1;
                  end
               end
               ACT_END: begin
                  if (q_stat.empty) begin
                     rsp_item_in.status = STAT_EMPTY;
                  end else begin
                     q_ctl.pop            = 1'b1;
                     rsp_item_in.duration = dur_end;
                     glob_in              = stats_add(glob_ff, dur_end);
                     if (enabled) begin
                        act_new      = stats_add(act_sel, dur_end);
                        st_ctl.wr_en = 1'b1;
                     end else begin
                        rsp_item_in.status = STAT_DISABLED;
                     end
                  end
               end
               ACT_DISCARD: begin
                  if (q_stat.empty) begin
                     rsp_item_in.status = STAT_EMPTY;
                  end else begin
                     q_ctl.pop            = 1'b1;
                     rsp_item_in.duration = diff_ff;
                     miss_count_in        = miss_count_ff + TICK_W'(1);
                     miss_ticks_in        = miss_ticks_ff + diff_ff;
                  end
               end
               ACT_READ: begin
                  if (!item_ff.read_global && !enabled) begin
                     rsp_item_in.status = STAT_DISABLED;
                  end
               end
               default: begin
                  rsp_item_in.status = STAT_OK;
               end
            endcase

            // Report the selected statistics as they stand after this item.
            if (item_ff.read_global) begin
               rsp_item_in.count_firings = glob_in.firings;
               rsp_item_in.sum_ticks     = glob_in.total;
               rsp_item_in.least_ticks   = glob_in.least;
               rsp_item_in.most_ticks    = glob_in.most;
            end else begin
               rsp_item_in.count_firings = act_new.firings;
               rsp_item_in.sum_ticks     = act_new.total;
               rsp_item_in.least_ticks   = act_new.least;
               rsp_item_in.most_ticks    = act_new.most;
            end
            rsp_item_in.missed_count = miss_count_in;
            rsp_item_in.missed_ticks = miss_ticks_in;
            rsp_valid_in             = 1'b1;
            state_in                 = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         glob_ff       <= STATS_RESET;
         miss_count_ff <= '0;
         miss_ticks_ff <= '0;
         mask_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         glob_ff       <= glob_in;
         miss_count_ff <= miss_count_in;
         miss_ticks_ff <= miss_ticks_in;
         mask_ff       <= mask_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff     <= item_in;
      diff_ff     <= diff_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   fdp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (q_ctl),
      .push_data(item_ff.timestamp),
      .head_data(head_data),
      .qstat    (q_stat)
   );

   fdp_action_stats u_action_stats (
      .clock  (clock),
      .reset  (reset),
      .ctl    (st_ctl),
      .wr_data(act_new),
      .rd_data(st_rd)
   );

   `FDP_ASSERT_NEXT(a_rsp_latency, accept, ##3 rsp_valid, "late or missing response")
   `FDP_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "response strobe longer than one cycle")

endmodule

// File: src/fdp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic                                         re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: src/fdp_queue.sv
// ----------------------------------------------------------------------------
// Start timestamp queue
// Circular FIFO of start timestamps in RAM with head pointer and fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "firing_duration_profiler_defines.svh"

module fdp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  fdp_pkg::queue_ctl_type       ctl,
   input  logic [fdp_pkg::TICK_W-1:0]   push_data,
   output logic [fdp_pkg::TICK_W-1:0]   head_data,
   output fdp_pkg::queue_stat_type      qstat
);

   import fdp_pkg::*;

   logic [QUEUE_AW-1:0] head_ff, head_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic [QUEUE_AW:0]   tail_sum;
   logic [QUEUE_AW-1:0] tail_addr;

   // Tail lies count entries past head, wrapped at the depth.
   always_comb begin
      tail_sum = {1'b0, head_ff} + (QUEUE_AW + 1)'(count_ff);
      if (tail_sum >= (QUEUE_AW + 1)'(QUEUE_DEPTH)) begin
         tail_addr = QUEUE_AW'(tail_sum - (QUEUE_AW + 1)'(QUEUE_DEPTH));
      end else begin
         tail_addr = QUEUE_AW'(tail_sum);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         head_in  = (head_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QUEUE_AW'(1);
         count_in = count_ff - QUEUE_CW'(1);
      end else if (ctl.push) begin
         count_in = count_ff + QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));

   fdp_ram #(
      .WIDTH(TICK_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_start_ram (
      .clock(clock),
      .we   (ctl.push),
      .waddr(tail_addr),
      .wdata(push_data),
      .re   (ctl.rd_en),
      .raddr(head_ff),
      .rdata(head_data)
   );

   `FDP_ASSERT_IMPL(a_no_push_full, ctl.push, !qstat.full, "push into full start queue")
   `FDP_ASSERT_IMPL(a_no_pop_empty, ctl.pop, !qstat.empty, "pop from empty start queue")
   `FDP_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= QUEUE_CW'(QUEUE_DEPTH), "queue overfilled")

endmodule

// File: src/fdp_action_stats.sv
// ----------------------------------------------------------------------------
// Per-action statistics store
// Records in RAM, a valid bit per action so unwritten records read as reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "firing_duration_profiler_defines.svh"

module fdp_action_stats (
   input  logic                    clock,
   input  logic                    reset,
   input  fdp_pkg::stats_ctl_type  ctl,
   input  fdp_pkg::stats_type      wr_data,
   output fdp_pkg::stats_type      rd_data
);

   import fdp_pkg::*;

   logic [ACTIONS-1:0]  valid_ff;
   logic                rd_valid_ff;
   logic [STATS_W-1:0]  ram_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[ctl.index] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[ctl.index];
         end
      end
   end

   fdp_ram #(
      .WIDTH(STATS_W),
      .DEPTH(ACTIONS)
   ) u_stats_ram (
      .clock(clock),
      .we   (ctl.wr_en),
      .waddr(ctl.index),
      .wdata(wr_data),
      .re   (ctl.rd_en),
      .raddr(ctl.index),
      .rdata(ram_q)
   );

   // Substitute reset values for a record never written.
   assign rd_data = rd_valid_ff ? stats_type'(ram_q) : STATS_RESET;

   `FDP_ASSERT_IMPL(a_rd_wr_apart, ctl.rd_en, !ctl.wr_en, "stats read and write overlap")

endmodule

// File: test/firing_duration_profiler_test.sv
// ----------------------------------------------------------------------------
// Firing duration profiler testbench
// Drives start, end, discard and read items through the command port under
// several enable masks and idle patterns. Each accepted item is scored
// against an in-bench tally of the queue, the global, per-action and miss
// statistics, compared field by field as the results come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module firing_duration_profiler_test;

   import fdp_pkg::*;

   // One statistics record as the bench tracks it.
   typedef struct packed {
      logic [TICK_W-1:0] firings;
      logic [TICK_W-1:0] total;
      logic [TICK_W-1:0] least;
      logic [TICK_W-1:0] most;
   } tally_type;

   // DUT ports; every input holds a known value from time zero.
   logic              clock;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic              busy;
   req_item_type      req_item  = '0;
   logic              rsp_valid;
   rsp_item_type      rsp_item;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [MASK_W-1:0] csr_data  = '0;

   // Bench copy of the block state.
   logic [TICK_W-1:0] open_starts[$];
   tally_type         all_tally;
   tally_type         action_tally[ACTIONS];
   logic [TICK_W-1:0] missed_events;
   logic [TICK_W-1:0] missed_span;
   logic [MASK_W-1:0] enable_mask;

   // Results predicted for accepted items, oldest first.
   rsp_item_type      firing_results_due[$];
   rsp_item_type      due_item;

   int                mismatches = 0;
   int                idle_pct   = 0;
   logic [TICK_W-1:0] tick_now   = '0;

   firing_duration_profiler u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Bound the run: the slowest legal run needs well under a tenth of this.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Bring the tally to its post-reset state: empty queue, mask clear.
   task automatic clear_tally();
      open_starts.delete();
      all_tally     = '{firings: '0, total: '0, least: '1, most: '0};
      for (int i = 0; i < ACTIONS; i++) begin
         action_tally[i] = all_tally;
      end
      missed_events = '0;
      missed_span   = '0;
      enable_mask   = '0;
   endtask

   // Fold one firing duration into a record; totals and counts wrap at 64 bits.
   function automatic tally_type tally_fold(tally_type t, logic [TICK_W-1:0] span);
      tally_type n;
      n         = t;
      n.firings = t.firings + 64'd1;
      n.total   = t.total + span;
      if (span < t.least) begin
         n.least = span;
      end
      if (span > t.most) begin
         n.most = span;
      end
      return n;
   endfunction

   // Apply one item to the tally and return the result the block must give.
   function automatic rsp_item_type predict_firing(req_item_type it);
      rsp_item_type      r;
      logic [TICK_W-1:0] span;
      logic              kept;
      tally_type         shown;
      r    = '0;
      span = '0;
      kept = enable_mask[it.act_slot];
      r.status = STAT_OK;
      case (it.action)
         ACT_START: begin
            if (open_starts.size() >= QUEUE_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               open_starts.push_back(it.timestamp);
            end
         end
         ACT_END: begin
            if (open_starts.size() == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               // A zero-length firing counts as one tick.
               span = it.timestamp - open_starts.pop_front();
               if (span == '0) begin
                  span = 64'd1;
               end
               all_tally = tally_fold(all_tally, span);
               if (kept) begin
                  action_tally[it.act_slot] =
                     tally_fold(action_tally[it.act_slot], span);
               end else begin
                  r.status = STAT_DISABLED;
               end
            end
         end
         ACT_DISCARD: begin
            if (open_starts.size() == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               // Misses keep the raw wrapped difference, zero included.
               span          = it.timestamp - open_starts.pop_front();
               missed_events = missed_events + 64'd1;
               missed_span   = missed_span + span;
            end
         end
         default: begin
            if (!it.read_global && !kept) begin
               r.status = STAT_DISABLED;
            end
         end
      endcase
      shown           = it.read_global ? all_tally : action_tally[it.act_slot];
      r.duration      = span;
      r.count_firings = shown.firings;
      r.sum_ticks     = shown.total;
      r.least_ticks   = shown.least;
      r.most_ticks    = shown.most;
      r.missed_count  = missed_events;
      r.missed_ticks  = missed_span;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(string what, logic [TICK_W-1:0] got,
                                  logic [TICK_W-1:0] wanted);
      mismatches++;
      $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, wanted);
   endtask

   task automatic check_field(string what, logic [TICK_W-1:0] got,
                              logic [TICK_W-1:0] wanted);
      if (got !== wanted) begin
         report_mismatch(what, got, wanted);
      end
   endtask

   // Sample at the edge that ends the strobe cycle; the block cannot be held.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (firing_results_due.size() == 0) begin
            report_mismatch("unexpected item, duration", rsp_item.duration, '0);
         end else begin
            due_item = firing_results_due.pop_front();
            check_field("status", TICK_W'(rsp_item.status), TICK_W'(due_item.status));
            check_field("duration",      rsp_item.duration,      due_item.duration);
            check_field("count_firings", rsp_item.count_firings, due_item.count_firings);
            check_field("sum_ticks",     rsp_item.sum_ticks,     due_item.sum_ticks);
            check_field("least_ticks",   rsp_item.least_ticks,   due_item.least_ticks);
            check_field("most_ticks",    rsp_item.most_ticks,    due_item.most_ticks);
            check_field("missed_count",  rsp_item.missed_count,  due_item.missed_count);
            check_field("missed_ticks",  rsp_item.missed_ticks,  due_item.missed_ticks);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic req_item_type firing_item(action_code_type act,
                                                logic [TICK_W-1:0] stamp,
                                                logic [INDEX_W-1:0] idx,
                                                logic glob);
      req_item_type it;
      it.action      = act;
      it.timestamp   = stamp;
      it.act_slot    = idx;
      it.read_global = glob;
      return it;
   endfunction

   // Offer one item and hold it until taken. start stays high on return, so
   // the caller either offers the next item or drops start in the same step.
   task automatic send_item(req_item_type it);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_item <= it;
      start    <= 1'b1;
      // busy read right at the edge is its value before the edge.
      do @(posedge clock); while (busy !== 1'b0);
      firing_results_due.push_back(predict_firing(it));
   endtask

   // Drop start and wait until every predicted result has come back, plus a margin.
   task automatic settle_block();
      start <= 1'b0;
      while (firing_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   // Write the enable mask; only ever done with the block idle.
   task automatic write_enable_mask(logic [MASK_W-1:0] mask);
      settle_block();
      csr_data  <= mask;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid   <= 1'b0;
      enable_mask  = mask;
   endtask

   // Mostly well-formed traffic around a running tick counter; a few items
   // are pure noise or end before their start to force wrapped durations.
   function automatic req_item_type next_random_item();
      req_item_type it;
      int           depth;
      int           pick;
      int           start_pct;
      depth = open_starts.size();
      pick  = $urandom_range(0, 99);
      if (pick < 6) begin
         it.action      = action_code_type'($urandom_range(0, 3));
         it.timestamp   = {$urandom, $urandom};
         it.act_slot    = INDEX_W'($urandom_range(0, ACTIONS - 1));
         it.read_global = 1'($urandom_range(0, 1));
         return it;
      end
      tick_now       = tick_now + TICK_W'($urandom_range(1, 40));
      it.timestamp   = tick_now;
      it.act_slot    = INDEX_W'($urandom_range(0, ACTIONS - 1));
      it.read_global = 1'($urandom_range(0, 1));
      if (pick < 9) begin
         it.timestamp = tick_now - TICK_W'($urandom_range(1, 200));
      end
      start_pct = (depth == 0) ? 75 : (depth >= 12) ? 20 : 40;
      pick      = $urandom_range(0, 99);
      if (pick < start_pct) begin
         it.action = ACT_START;
      end else if (pick < start_pct + 35) begin
         it.action = ACT_END;
      end else if (pick < start_pct + 45) begin
         it.action = ACT_DISCARD;
      end else begin
         it.action = ACT_READ;
      end
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Pops on an empty queue and reads with every action disabled.
   task automatic test_empty_queue();
      send_item(firing_item(ACT_END,     64'd100, 4'd0,  1'b0));
      send_item(firing_item(ACT_DISCARD, '1,      4'd15, 1'b1));
      send_item(firing_item(ACT_READ,    '0,      4'd0,  1'b1));
      send_item(firing_item(ACT_READ,    '1,      4'd15, 1'b0));
   endtask

   // Zero-length firings, wrapped differences and a wrapping total.
   task automatic test_duration_edges();
      // zero length clamps to one
      send_item(firing_item(ACT_START,   '0,      4'd0,  1'b0));
      send_item(firing_item(ACT_END,     '0,      4'd0,  1'b0));
      // end past the wrap of the tick counter
      send_item(firing_item(ACT_START,   '1,      4'd15, 1'b1));
      send_item(firing_item(ACT_END,     '0,      4'd15, 1'b0));
      // end one tick before start: near-maximal duration, twice on one action
      send_item(firing_item(ACT_START,   64'd5,   4'd3,  1'b0));
      send_item(firing_item(ACT_END,     64'd4,   4'd3,  1'b0));
      send_item(firing_item(ACT_START,   64'd10,  4'd3,  1'b1));
      send_item(firing_item(ACT_END,     64'd9,   4'd3,  1'b0));
      // discards keep a zero difference and wrap too
      send_item(firing_item(ACT_START,   64'd7,   4'd8,  1'b0));
      send_item(firing_item(ACT_DISCARD, 64'd7,   4'd8,  1'b1));
      send_item(firing_item(ACT_START,   '1,      4'd9,  1'b0));
      send_item(firing_item(ACT_DISCARD, 64'd1,   4'd9,  1'b0));
      send_item(firing_item(ACT_READ,    '0,      4'd3,  1'b1));
      send_item(firing_item(ACT_READ,    '0,      4'd3,  1'b0));
   endtask

   // Values of a disabled action stay readable; its ends still count globally.
   task automatic test_mask_change();
      send_item(firing_item(ACT_READ,  '0,       4'd3, 1'b0));
      send_item(firing_item(ACT_START, 64'd500,  4'd3, 1'b0));
      send_item(firing_item(ACT_END,   64'd620,  4'd3, 1'b0));
      send_item(firing_item(ACT_START, 64'd700,  4'd2, 1'b0));
      send_item(firing_item(ACT_END,   64'd701,  4'd2, 1'b0));
      send_item(firing_item(ACT_READ,  '0,       4'd2, 1'b1));
   endtask

   // Overfill the start queue, then drain it one pop past empty.
   task automatic test_full_queue();
      int extra;
      extra = $urandom_range(1, 3);
      repeat (QUEUE_DEPTH + extra) begin
         tick_now = tick_now + TICK_W'($urandom_range(1, 9));
         send_item(firing_item(ACT_START, tick_now,
                               INDEX_W'($urandom_range(0, ACTIONS - 1)),
                               1'($urandom_range(0, 1))));
      end
      repeat (QUEUE_DEPTH + 1) begin
         tick_now = tick_now + TICK_W'($urandom_range(1, 300));
         send_item(firing_item($urandom_range(0, 3) == 0 ? ACT_DISCARD : ACT_END,
                               tick_now, INDEX_W'($urandom_range(0, ACTIONS - 1)),
                               1'($urandom_range(0, 1))));
      end
   endtask

   // Random traffic; halfway through, hold the sender until the block drains.
   task automatic test_random_traffic(int count);
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) begin
            settle_block();
         end
         send_item(next_random_item());
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      clear_tally();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Mask holds its reset value here: every action disabled.
      test_empty_queue();

      write_enable_mask('1);
      test_duration_edges();

      // Disable action 3, which now holds statistics; keep 0 and 2.
      write_enable_mask(16'h0005);
      test_mask_change();

      write_enable_mask(16'($urandom));
      tick_now = {$urandom, $urandom};
      test_full_queue();

      // Back to back, all actions kept.
      write_enable_mask('1);
      idle_pct = 0;
      test_random_traffic(125);

      // Sender idles often; counter starts just short of its wrap.
      write_enable_mask(16'($urandom));
      idle_pct = 61;
      tick_now = '1 - TICK_W'($urandom_range(0, 3000));
      test_random_traffic(125);

      // Everything disabled, moderate idling.
      write_enable_mask('0);
      idle_pct = 31;
      test_random_traffic(125);

      // Only the outer actions kept, no idling.
      write_enable_mask(16'h8001);
      idle_pct = 0;
      test_random_traffic(125);

      settle_block();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
